>>> hdl/ptw_pkg.sv
package ptw_pkg;

   localparam int WHEEL_SLOTS = 4;
   localparam int MAX_TIMERS  = 16;

   localparam int KIND_W     = 2;
   localparam int ID_W       = 4;
   localparam int PERIOD_W   = 16;
   localparam int PERIOD_MAX = (1 << PERIOD_W) - 1;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   localparam int SLOT_W = (WHEEL_SLOTS > 2) ? $clog2(WHEEL_SLOTS) : 1;
   localparam int QUOT_W = $clog2((PERIOD_MAX / WHEEL_SLOTS) + 1);
   localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CNT_W  = $clog2(PERIOD_W + 1);

   localparam logic [SLOT_W:0]   SLOTS_C     = (SLOT_W + 1)'(WHEEL_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT_C = SLOT_W'(WHEEL_SLOTS - 1);
   localparam logic [IDX_W-1:0]  LAST_IDX_C  = IDX_W'(MAX_TIMERS - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_REG   = 2'd1,
      KIND_UNREG = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic            status;
      logic            fired_valid;
      logic [ID_W-1:0] fired_id;
      logic            last;
   } rsp_word_type;

   function automatic logic id_in_range(input logic [ID_W-1:0] id);
      return (32'(id) < MAX_TIMERS);
   endfunction

endpackage

>>> hdl/ptw_div.sv
module ptw_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ptw_pkg::PERIOD_W-1:0]   dividend,
   output logic                           done,
   output logic [ptw_pkg::QUOT_W-1:0]     quot,
   output logic [ptw_pkg::SLOT_W-1:0]     rem
);
   import ptw_pkg::*;

   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic              done_ff, done_in;

   // The slot count is a power of two, so the division reduces to a shift and a mask.
   always_comb begin
      done_in = start;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         quot_in = QUOT_W'(dividend / PERIOD_W'(WHEEL_SLOTS));
         rem_in  = SLOT_W'(dividend % PERIOD_W'(WHEEL_SLOTS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

>>> hdl/ptw_out.sv
module ptw_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  ptw_pkg::rsp_word_type           word,
   output logic                            free,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ptw_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // fired_id
   output logic [ptw_pkg::RSP_USER_W-1:0]  rsp_tuser,  // fired_valid, status
   output logic                            rsp_tlast
);
   import ptw_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   always_comb begin
      free     = !valid_ff || rsp_tready;
      valid_in = valid_ff && !rsp_tready;
      word_in  = word_ff;
      if (load && free) begin
         valid_in = 1'b1;
         word_in  = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(word_ff.fired_id);
   assign rsp_tuser  = {word_ff.status, word_ff.fired_valid};
   assign rsp_tlast  = word_ff.last;

endmodule

>>> hdl/periodic_timer_wheel_unit.sv
// A tick scans one timer entry per cycle, except while a full output register holds back an
// expiry, and then hands over its last word from ST_FIN.
// A registration with a nonzero period and a valid id passes through ST_DIV, where the divider
// splits the period into rounds and slot; other non-tick requests go straight to ST_DONE.
// The next word is accepted in the cycle after the last result word enters the output register.
// Synchronous reset disarms all timers and sets the slot pointer to zero, with no sweep.
module periodic_timer_wheel_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ptw_pkg::REQ_DATA_W-1:0]  req_tdata,  // timer_id, period_ticks
   input  logic [ptw_pkg::KIND_W-1:0]      req_tuser,  // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ptw_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // fired_id
   output logic [ptw_pkg::RSP_USER_W-1:0]  rsp_tuser,  // fired_valid, status
   output logic                            rsp_tlast
);
   import ptw_pkg::*;

   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [ID_W-1:0]     pend_id_ff, pend_id_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic                status_ff, status_in;

   logic                armed_ff [MAX_TIMERS];
   logic [SLOT_W-1:0]   slot_ff [MAX_TIMERS];
   logic [QUOT_W-1:0]   rounds_ff [MAX_TIMERS];
   logic [QUOT_W-1:0]   quot_ff [MAX_TIMERS];
   logic [SLOT_W-1:0]   rem_ff [MAX_TIMERS];

   logic [ID_W-1:0]     req_id;
   logic [PERIOD_W-1:0] req_period;
   logic [IDX_W-1:0]    addr;
   logic                ent_armed;
   logic [SLOT_W-1:0]   ent_slot;
   logic [QUOT_W-1:0]   ent_rounds;
   logic [QUOT_W-1:0]   arm_q;
   logic [SLOT_W-1:0]   arm_r;
   logic [SLOT_W:0]     slot_sum;
   logic [SLOT_W-1:0]   arm_slot;
   logic [QUOT_W-1:0]   arm_rounds;
   logic                hit;
   logic                fire;

   logic                div_start;
   logic                div_done;
   logic [QUOT_W-1:0]   div_quot;
   logic [SLOT_W-1:0]   div_rem;

   logic                arm_we;
   logic                dec_we;
   logic                clr_we;
   logic                out_load;
   logic                out_free;
   rsp_word_type        out_word;

   assign req_id     = req_tdata[ID_W-1:0];
   assign req_period = req_tdata[ID_W+PERIOD_W-1:ID_W];

   ptw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_period),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   ptw_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .word       (out_word),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The quotient and remainder of the period are kept per timer, so a re-arm needs no divide.
   always_comb begin
      addr       = (state_ff == ST_SCAN) ? idx_ff : IDX_W'(id_ff);
      ent_armed  = armed_ff[addr];
      ent_slot   = slot_ff[addr];
      ent_rounds = rounds_ff[addr];
      arm_q      = (state_ff == ST_DIV) ? div_quot : quot_ff[addr];
      arm_r      = (state_ff == ST_DIV) ? div_rem : rem_ff[addr];
      slot_sum   = {1'b0, cur_ff} + {1'b0, arm_r};
      arm_slot   = (slot_sum >= SLOTS_C) ? SLOT_W'(slot_sum - SLOTS_C) : SLOT_W'(slot_sum);
      arm_rounds = (arm_r == '0) ? (arm_q - QUOT_W'(1)) : arm_q;
      hit        = ent_armed && (ent_slot == cur_ff);
      fire       = hit && (ent_rounds == '0);
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      pend_id_in = pend_id_ff;
      id_in      = id_ff;
      status_in  = status_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      arm_we     = 1'b0;
      dec_we     = 1'b0;
      clr_we     = 1'b0;
      out_load   = 1'b0;
      out_word   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               id_in     = req_id;
               status_in = 1'b0;
               unique case (kind_type'(req_tuser))
                  KIND_TICK: begin
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  KIND_REG: begin
                     if (req_period == '0) begin
                        status_in = 1'b1;
                        state_in  = ST_DONE;
                     end else if (id_in_range(req_id)) begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  KIND_UNREG: begin
                     clr_we   = id_in_range(req_id);
                     state_in = ST_DONE;
                  end
                  KIND_NONE: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               arm_we   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            // An earlier expiry is held back until a later one shows it was not the last.
            if (!(fire && pend_ff && !out_free)) begin
               if (fire) begin
                  arm_we               = 1'b1;
                  out_load             = pend_ff;
                  out_word.fired_valid = 1'b1;
                  out_word.fired_id    = pend_id_ff;
                  pend_in              = 1'b1;
                  pend_id_in           = ID_W'(idx_ff);
               end else if (hit) begin
                  dec_we = 1'b1;
               end
               if (idx_ff == LAST_IDX_C) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               out_load             = 1'b1;
               out_word.fired_valid = pend_ff;
               out_word.fired_id    = pend_ff ? pend_id_ff : '0;
               out_word.last        = 1'b1;
               cur_in               = (cur_ff == LAST_SLOT_C) ? '0 : cur_ff + SLOT_W'(1);
               state_in             = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_load        = 1'b1;
               out_word.status = status_ff;
               out_word.last   = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff <= pend_id_in;
      id_ff      <= id_in;
      status_ff  <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TIMERS; i++) begin
            armed_ff[i] <= 1'b0;
         end
      end else if (clr_we) begin
         armed_ff[IDX_W'(req_id)] <= 1'b0;
      end else if (arm_we) begin
         armed_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (arm_we) begin
         slot_ff[addr]   <= arm_slot;
         rounds_ff[addr] <= arm_rounds;
         quot_ff[addr]   <= arm_q;
         rem_ff[addr]    <= arm_r;
      end else if (dec_we) begin
         rounds_ff[addr] <= ent_rounds - QUOT_W'(1);
      end
   end

endmodule

>>> tb/sv/periodic_timer_wheel_unit_tb.sv
`timescale 1ns / 1ps

module periodic_timer_wheel_unit_tb;
   import ptw_pkg::*;

   localparam int          HALF_PERIOD  = 4;
   localparam int          RANDOM_WORDS = 310;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int          DRAIN_CYCLES = 2 * MAX_TIMERS + 16;
   localparam int          REPORT_MAX   = 10;

   typedef struct packed {
      kind_type              kind;
      logic [ID_W-1:0]       id;
      logic [PERIOD_W-1:0]   period;
   } timer_cmd_type;

   typedef struct packed {
      logic            fired_valid;
      logic [ID_W-1:0] fired_id;
      logic            status;
      logic            last;
   } fire_word_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [KIND_W-1:0]       req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    rsp_tlast;

   timer_cmd_type  pending_cmds[$];
   fire_word_type  fired_words[$];

   logic                armed_tab[MAX_TIMERS];
   logic [SLOT_W-1:0]   slot_tab[MAX_TIMERS];
   logic [PERIOD_W-1:0] rounds_tab[MAX_TIMERS];
   logic [PERIOD_W-1:0] period_tab[MAX_TIMERS];
   logic [SLOT_W-1:0]   wheel_pos;

   int unsigned cycle_count = 0;
   int          error_count = 0;

   periodic_timer_wheel_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic take_break();
      if (cycle_count >= 1500 && cycle_count < 3000) begin
         return 1'b0;
      end
      return ($urandom_range(99, 0) < 23);
   endfunction

   function automatic void arm_timer(input int idx, input logic [PERIOD_W-1:0] period);
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] rounds;
      slot   = SLOT_W'((int'(wheel_pos) + int'(period)) % WHEEL_SLOTS);
      rounds = PERIOD_W'(int'(period) / WHEEL_SLOTS);
      if (slot == wheel_pos && rounds != '0) begin
         rounds = rounds - 1'b1;
      end
      slot_tab[idx]   = slot;
      rounds_tab[idx] = rounds;
      period_tab[idx] = period;
      armed_tab[idx]  = 1'b1;
   endfunction

   function automatic void push_word(input logic valid, input logic [ID_W-1:0] id,
                                     input logic status, input logic last);
      fire_word_type w;
      w.fired_valid = valid;
      w.fired_id    = id;
      w.status      = status;
      w.last        = last;
      fired_words   = {fired_words, w};
   endfunction

   // Applies one accepted word to the wheel and queues the words it should produce.
   function automatic void advance_wheel(input timer_cmd_type cmd);
      int fired;
      fired = 0;
      case (cmd.kind)
         KIND_TICK: begin
            for (int i = 0; i < MAX_TIMERS; i++) begin
               if (armed_tab[i] && slot_tab[i] == wheel_pos) begin
                  if (rounds_tab[i] == '0) begin
                     push_word(1'b1, ID_W'(i), 1'b0, 1'b0);
                     fired++;
                     arm_timer(i, period_tab[i]);
                  end else begin
                     rounds_tab[i] = rounds_tab[i] - 1'b1;
                  end
               end
            end
            wheel_pos = (wheel_pos == LAST_SLOT_C) ? '0 : wheel_pos + 1'b1;
            if (fired == 0) begin
               push_word(1'b0, '0, 1'b0, 1'b1);
            end else begin
               fired_words[fired_words.size() - 1].last = 1'b1;
            end
         end
         KIND_REG: begin
            if (cmd.period == '0) begin
               push_word(1'b0, '0, 1'b1, 1'b1);
            end else begin
               if (int'(cmd.id) < MAX_TIMERS) begin
                  arm_timer(int'(cmd.id), cmd.period);
               end
               push_word(1'b0, '0, 1'b0, 1'b1);
            end
         end
         KIND_UNREG: begin
            if (int'(cmd.id) < MAX_TIMERS) begin
               armed_tab[cmd.id] = 1'b0;
            end
            push_word(1'b0, '0, 1'b0, 1'b1);
         end
         default: begin
            push_word(1'b0, '0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   function automatic void add_cmd(input kind_type kind, input int id, input int period);
      timer_cmd_type cmd;
      cmd.kind     = kind;
      cmd.id       = ID_W'(id);
      cmd.period   = PERIOD_W'(period);
      pending_cmds = {pending_cmds, cmd};
   endfunction

   always @(posedge clock) begin
      timer_cmd_type cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
         for (int i = 0; i < MAX_TIMERS; i++) begin
            armed_tab[i] = 1'b0;
         end
         wheel_pos = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            cmd.kind   = kind_type'(req_tuser);
            cmd.id     = req_tdata[ID_W-1:0];
            cmd.period = req_tdata[ID_W +: PERIOD_W];
            advance_wheel(cmd);
         end
         if ((!req_tvalid || req_tready) ) begin
            if (pending_cmds.size() > 0 && !take_break()) begin
               cmd = pending_cmds.pop_front();
               req_tdata  <= REQ_DATA_W'({cmd.period, cmd.id});
               req_tuser  <= cmd.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      fire_word_type want;
      fire_word_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !take_break();
         if (rsp_tvalid && rsp_tready) begin
            got.fired_id    = rsp_tdata[ID_W-1:0];
            got.fired_valid = rsp_tuser[0];
            got.status      = rsp_tuser[1];
            got.last        = rsp_tlast;
            if (fired_words.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("unexpected word: valid %0b id %0d status %0b last %0b",
                           got.fired_valid, got.fired_id, got.status, got.last);
               end
            end else begin
               want = fired_words.pop_front();
               if (got != want) begin
                  error_count++;
                  if (error_count <= REPORT_MAX) begin
                     $display("mismatch: expected valid %0b id %0d status %0b last %0b,",
                              want.fired_valid, want.fired_id, want.status, want.last,
                              " got valid %0b id %0d status %0b last %0b",
                              got.fired_valid, got.fired_id, got.status, got.last);
                  end
               end
            end
         end
      end
   end

   initial begin
      int pick;
      int period;
      add_cmd(KIND_REG, 0, 1);
      add_cmd(KIND_REG, 15, 1);
      add_cmd(KIND_REG, 5, 4);
      add_cmd(KIND_REG, 3, 0);
      add_cmd(KIND_REG, 9, 65535);
      add_cmd(KIND_UNREG, 7, 0);
      add_cmd(KIND_NONE, 10, 16'haaaa);
      add_cmd(KIND_TICK, 0, 0);
      add_cmd(KIND_TICK, 15, 16'hffff);
      add_cmd(KIND_TICK, 0, 0);
      add_cmd(KIND_REG, 0, 2);
      add_cmd(KIND_UNREG, 15, 0);
      add_cmd(KIND_TICK, 0, 0);
      add_cmd(KIND_TICK, 0, 0);
      add_cmd(KIND_REG, 10, 16'h5555);
      add_cmd(KIND_UNREG, 10, 16'haaaa);
      add_cmd(KIND_REG, 12, 3);
      add_cmd(KIND_TICK, 0, 0);
      add_cmd(KIND_TICK, 0, 0);
      add_cmd(KIND_TICK, 0, 0);
      add_cmd(KIND_UNREG, 9, 0);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(99, 0);
         if (pick < 42) begin
            add_cmd(KIND_TICK, $urandom_range(15, 0), $urandom_range(65535, 0));
         end else if (pick < 80) begin
            pick = $urandom_range(99, 0);
            if (pick < 72) begin
               period = $urandom_range(12, 1);
            end else if (pick < 84) begin
               period = $urandom_range(64, 13);
            end else if (pick < 94) begin
               period = $urandom_range(65535, 0);
            end else begin
               period = 0;
            end
            add_cmd(KIND_REG, $urandom_range(15, 0), period);
         end else if (pick < 94) begin
            add_cmd(KIND_UNREG, $urandom_range(15, 0), $urandom_range(65535, 0));
         end else begin
            add_cmd(KIND_NONE, $urandom_range(15, 0), $urandom_range(65535, 0));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (pending_cmds.size() == 0 && !req_tvalid && fired_words.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
